>>> rtl/camera_lidar_obstacle_fusion_macros.svh
// ----------------------------------------------------------------------------
// camera lidar obstacle fusion assertion macros
// shared property forms for the fusion block
// ----------------------------------------------------------------------------
`ifndef CAMERA_LIDAR_OBSTACLE_FUSION_MACROS_SVH
`define CAMERA_LIDAR_OBSTACLE_FUSION_MACROS_SVH

`ifndef SYNTH
`define CLOF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clof assertion failed");
`define CLOF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clof assertion failed");
`else
`define CLOF_ASSERT_IMP(label, clk, rst, ante, cons)
`define CLOF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/clof_pkg.sv
// ----------------------------------------------------------------------------
// clof_pkg
// types, constants and helper functions of the obstacle fusion block
// ----------------------------------------------------------------------------
package clof_pkg;

   localparam int MAX_CAMERA_DEF   = 16;
   localparam int MAX_LIDAR_DEF    = 32;
   localparam int CORDIC_STEPS_DEF = 18;
   localparam int MAX_RESULTS      = 32;

   // datapath widths
   localparam int CW   = 48;   // cordic x / y
   localparam int ZW   = 22;   // cordic angle
   localparam int MW   = 33;   // multiplier operand
   localparam int PW   = 66;   // multiplier product
   localparam int SATW = 68;   // saturating sums
   localparam int DNW  = 34;   // divider numerator / quotient
   localparam int IDXW = 6;

   localparam int PI_Q16      = 205887;
   localparam int HALF_PI_Q16 = 102944;
   localparam int KGAIN_Q16   = 39797;
   localparam int ONE_Q16     = 65536;

   localparam logic [1:0] ACT_CAMERA = 2'd0;
   localparam logic [1:0] ACT_LIDAR  = 2'd1;
   localparam logic [1:0] ACT_FUSE   = 2'd2;

   localparam logic KIND_CAMERA = 1'b0;
   localparam logic KIND_LIDAR  = 1'b1;

   localparam logic [2:0] REG_CAR_POS_X      = 3'd0;
   localparam logic [2:0] REG_CAR_POS_Y      = 3'd1;
   localparam logic [2:0] REG_CAR_HEADING    = 3'd2;
   localparam logic [2:0] REG_TAN_HALF_VIEW  = 3'd3;
   localparam logic [2:0] REG_CAMERA_OFFSET  = 3'd4;
   localparam logic [2:0] REG_HALF_IMG_WIDTH = 3'd5;
   localparam logic [2:0] REG_RADIUS_GAIN    = 3'd6;

   localparam logic [17:0] TAN_HALF_VIEW_RST  = 18'd60052;
   localparam logic [19:0] CAMERA_OFFSET_RST  = 20'd144179;
   localparam logic [11:0] HALF_IMG_WIDTH_RST = 12'd640;
   localparam logic [17:0] RADIUS_GAIN_RST    = 18'd72090;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_NUM_U,
      ST_NUM_T,
      ST_DIV_U,
      ST_LD_T,
      ST_DIV_T,
      ST_VEC,
      ST_VEC_W,
      ST_KD,
      ST_ROT_D,
      ST_ROT_D_W,
      ST_RAD,
      ST_RAD_W,
      ST_INF,
      ST_OX,
      ST_ROT_O,
      ST_ROT_O_W,
      ST_PX,
      ST_PY,
      ST_ROT_P,
      ST_ROT_P_W,
      ST_SUM,
      ST_CAM_OUT,
      ST_FL_RD,
      ST_FL_LD,
      ST_FC_RD,
      ST_FC_A,
      ST_FC_B,
      ST_FC_C,
      ST_FUSE_OUT
   } fsm_state_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_stat_type;

   function automatic logic [15:0] atan_lut(input logic [4:0] i);
      logic [15:0] v;
      case (i)
         5'd0:    v = 16'd51472;
         5'd1:    v = 16'd30386;
         5'd2:    v = 16'd16055;
         5'd3:    v = 16'd8150;
         5'd4:    v = 16'd4091;
         5'd5:    v = 16'd2047;
         5'd6:    v = 16'd1024;
         5'd7:    v = 16'd512;
         5'd8:    v = 16'd256;
         5'd9:    v = 16'd128;
         5'd10:   v = 16'd64;
         5'd11:   v = 16'd32;
         5'd12:   v = 16'd16;
         5'd13:   v = 16'd8;
         5'd14:   v = 16'd4;
         5'd15:   v = 16'd2;
         5'd16:   v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] v);
      logic signed [31:0] r;
      if (v > SATW'(64'sh7FFF_FFFF)) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -SATW'(64'sh8000_0000)) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/clof_if.sv
// ----------------------------------------------------------------------------
// clof channel interfaces
// request, response and register write channels with valid / ready
// ----------------------------------------------------------------------------
interface clof_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  action;
   logic        [7:0]  class_id;
   logic        [12:0] box_width;
   logic        [12:0] center_col;
   logic        [23:0] depth;
   logic signed [31:0] lidar_x;
   logic signed [31:0] lidar_y;

   modport source (output valid, action, class_id, box_width, center_col, depth,
                   lidar_x, lidar_y, input ready);
   modport sink   (input valid, action, class_id, box_width, center_col, depth,
                   lidar_x, lidar_y, output ready);
endinterface

interface clof_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic        [5:0]  entry_index;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] obstacle_radius;
   logic signed [31:0] inflated_radius;
   logic        [7:0]  fused_class;
   logic               last;

   modport source (output valid, kind, entry_index, pos_x, pos_y, obstacle_radius,
                   inflated_radius, fused_class, last, input ready);
   modport sink   (input valid, kind, entry_index, pos_x, pos_y, obstacle_radius,
                   inflated_radius, fused_class, last, output ready);
endinterface

interface clof_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/clof_ram.sv
// ----------------------------------------------------------------------------
// clof_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module clof_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/clof_cordic.sv
// ----------------------------------------------------------------------------
// clof_cordic
// iterative cordic, one micro-rotation per cycle, vectoring or rotation
// ----------------------------------------------------------------------------
module clof_cordic #(
   parameter int STEPS = clof_pkg::CORDIC_STEPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  clof_pkg::cordic_cmd_type         cmd,
   input  logic signed [clof_pkg::CW-1:0]   x_in,
   input  logic signed [clof_pkg::CW-1:0]   y_in,
   input  logic signed [clof_pkg::ZW-1:0]   z_in,
   output clof_pkg::cordic_stat_type        stat,
   output logic signed [clof_pkg::CW-1:0]   x_out,
   output logic signed [clof_pkg::CW-1:0]   y_out,
   output logic signed [clof_pkg::ZW-1:0]   z_out
);
   import clof_pkg::*;

   localparam logic signed [ZW-1:0] ZPI   = ZW'(PI_Q16);
   localparam logic signed [ZW-1:0] ZHALF = ZW'(HALF_PI_Q16);
   localparam logic [4:0]           LAST  = 5'(STEPS - 1);

   logic signed [CW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;
   logic                 vec_ff;
   logic [4:0]           step_ff;
   logic                 busy_ff, done_ff;

   logic signed [CW-1:0] xs, ys;
   logic signed [ZW-1:0] ang;
   logic                 up;

   always_comb begin
      xs  = x_ff >>> step_ff;
      ys  = y_ff >>> step_ff;
      ang = ZW'($signed({1'b0, atan_lut(step_ff)}));
      up  = vec_ff ? !y_ff[CW-1] : z_ff[ZW-1];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         vec_ff <= cmd.vectoring;
         if (!cmd.vectoring && (z_in > ZHALF)) begin
            x_ff <= -x_in;
            y_ff <= -y_in;
            z_ff <= z_in - ZPI;
         end else if (!cmd.vectoring && (z_in < -ZHALF)) begin
            x_ff <= -x_in;
            y_ff <= -y_in;
            z_ff <= z_in + ZPI;
         end else begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= z_in;
         end
      end else if (busy_ff) begin
         if (up) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + ang;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 5'd1;
            if (step_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
endmodule

>>> rtl/camera_lidar_obstacle_fusion.sv
// ----------------------------------------------------------------------------
// camera_lidar_obstacle_fusion
// deprojects camera detections to the map frame, stores them with lidar
// circle centers and labels each lidar center on a fuse request
// ----------------------------------------------------------------------------
// A camera request runs two bit-serial divisions for the bearing and the radius
// slope, then four passes of the shared cordic unit. A lidar request is stored
// in the lidar table, if it has room, straight from idle. A fuse request reads
// each lidar center and scans the camera entries until the first match, one
// table read at a time. The next request is taken as soon as the block is idle,
// while a result may still wait in the output register. Tables need no clearing
// pass after reset.
`include "camera_lidar_obstacle_fusion_macros.svh"

module camera_lidar_obstacle_fusion #(
   parameter int MAX_CAMERA   = clof_pkg::MAX_CAMERA_DEF,
   parameter int MAX_LIDAR    = clof_pkg::MAX_LIDAR_DEF,
   parameter int CORDIC_STEPS = clof_pkg::CORDIC_STEPS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   clof_req_if.sink   req_chan,
   clof_rsp_if.source rsp_chan,
   clof_csr_if.sink   csr_chan
);
   import clof_pkg::*;

   localparam int CCW = $clog2(MAX_CAMERA + 1);
   localparam int LCW = $clog2(MAX_LIDAR + 1);
   localparam int CAW = (MAX_CAMERA > 1) ? $clog2(MAX_CAMERA) : 1;
   localparam int LAW = (MAX_LIDAR > 1) ? $clog2(MAX_LIDAR) : 1;
   localparam int CMW = 8 + 3 * 32;
   localparam int LMW = 64;

   localparam logic signed [MW-1:0] KGAIN = MW'(KGAIN_Q16);

   // registers
   logic signed [31:0] car_x_ff, car_y_ff;
   logic signed [18:0] heading_ff;
   logic [17:0]        tanh_ff;
   logic [19:0]        offset_ff;
   logic [11:0]        half_reg_ff;
   logic [17:0]        gain_ff;

   fsm_state_type state_ff, state_in;
   logic [CCW-1:0] cam_count_ff;
   logic [LCW-1:0] lidar_count_ff;
   logic [IDXW-1:0] j_ff, nres_ff;
   logic [CCW-1:0] c_ff;

   // request payload
   logic [7:0]  cls_ff;
   logic [12:0] w_ff, cx_ff;
   logic [23:0] d_ff;
   logic [11:0] half_ff;

   // datapath
   logic signed [PW-1:0] prod_ff;
   logic [DNW-1:0]       div_num_ff;
   logic [12:0]          div_rem_ff, div_den_ff;
   logic                 div_neg_ff;
   logic [5:0]           div_cnt_ff;
   logic signed [31:0]   u_ff, t2_ff, rad_ff, infl_ff, posx_ff, posy_ff;
   logic signed [ZW-1:0] theta_ff;
   logic signed [CW-1:0] dx_ff, dy_ff, ox_ff, oy_ff, pxk_ff;
   logic signed [31:0]   lx_ff, ly_ff;
   logic [7:0]           cls_c_ff, match_ff;
   logic                 ok_ff, hit_ok_ff;
   logic [30:0]          ex_ff, ey_ff, r_ff;
   logic [62:0]          sq_ff;
   logic [61:0]          rr_ff;

   // output register
   logic               out_valid_ff;
   logic               out_kind_ff, out_last_ff;
   logic [IDXW-1:0]    out_idx_ff;
   logic signed [31:0] out_px_ff, out_py_ff, out_rad_ff, out_infl_ff;
   logic [7:0]         out_cls_ff;

   // control
   logic req_fire, out_free, out_load, mul_en, cam_we, lidar_we, fuse_done, fuse_last;
   logic hit, cam_last;
   logic signed [MW-1:0] mul_a, mul_b;
   cordic_cmd_type       cordic_cmd;
   cordic_stat_type      cordic_stat;
   logic signed [CW-1:0] cx_in, cy_in, cx_out, cy_out;
   logic signed [ZW-1:0] cz_in, cz_out, yaw;

   logic signed [14:0] diff;
   logic signed [16:0] diff2w;
   logic [13:0]        rem_sh;
   logic               div_ge;
   logic [DNW-1:0]     quot;
   logic signed [PW-1:0] prod_abs;
   logic signed [32:0] ex, ey, exa, eya;

   logic [CMW-1:0] cam_wdata, cam_rdata;
   logic [LMW-1:0] lidar_rdata;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign yaw      = ZW'(heading_ff);
   assign csr_chan.ready = 1'b1;

   assign diff   = $signed({3'b000, half_ff}) - $signed({2'b00, cx_ff});
   assign diff2w = (17'(diff) <<< 1) + $signed({4'b0000, w_ff});

   assign rem_sh   = {div_rem_ff, div_num_ff[DNW-1]};
   assign div_ge   = rem_sh >= {1'b0, div_den_ff};
   assign quot     = div_neg_ff ? -div_num_ff : div_num_ff;
   assign prod_abs = prod_ff[PW-1] ? -prod_ff : prod_ff;

   assign ex  = $signed({cam_rdata[95], cam_rdata[95:64]}) - $signed({lx_ff[31], lx_ff});
   assign ey  = $signed({cam_rdata[63], cam_rdata[63:32]}) - $signed({ly_ff[31], ly_ff});
   assign exa = ex[32] ? -ex : ex;
   assign eya = ey[32] ? -ey : ey;

   assign hit       = hit_ok_ff && ({1'b0, sq_ff[62:0]} < {2'b00, rr_ff});
   assign cam_last  = CCW'(c_ff + 1'b1) == cam_count_ff;
   assign fuse_last = (j_ff + 6'd1) == nres_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         car_x_ff    <= '0;
         car_y_ff    <= '0;
         heading_ff  <= '0;
         tanh_ff     <= TAN_HALF_VIEW_RST;
         offset_ff   <= CAMERA_OFFSET_RST;
         half_reg_ff <= HALF_IMG_WIDTH_RST;
         gain_ff     <= RADIUS_GAIN_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_CAR_POS_X:      car_x_ff    <= csr_chan.data;
            REG_CAR_POS_Y:      car_y_ff    <= csr_chan.data;
            REG_CAR_HEADING:    heading_ff  <= csr_chan.data[18:0];
            REG_TAN_HALF_VIEW:  tanh_ff     <= csr_chan.data[17:0];
            REG_CAMERA_OFFSET:  offset_ff   <= csr_chan.data[19:0];
            REG_HALF_IMG_WIDTH: half_reg_ff <= csr_chan.data[11:0];
            REG_RADIUS_GAIN:    gain_ff     <= csr_chan.data[17:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.action)
                  ACT_CAMERA: state_in = ST_NUM_U;
                  ACT_FUSE:   state_in = (lidar_count_ff != '0) ? ST_FL_RD : ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_NUM_U:   state_in = ST_NUM_T;
         ST_NUM_T:   state_in = ST_DIV_U;
         ST_DIV_U:   state_in = (div_cnt_ff == 6'd1) ? ST_LD_T : ST_DIV_U;
         ST_LD_T:    state_in = ST_DIV_T;
         ST_DIV_T:   state_in = (div_cnt_ff == 6'd1) ? ST_VEC : ST_DIV_T;
         ST_VEC:     state_in = ST_VEC_W;
         ST_VEC_W:   state_in = cordic_stat.done ? ST_KD : ST_VEC_W;
         ST_KD:      state_in = ST_ROT_D;
         ST_ROT_D:   state_in = ST_ROT_D_W;
         ST_ROT_D_W: state_in = cordic_stat.done ? ST_RAD : ST_ROT_D_W;
         ST_RAD:     state_in = ST_RAD_W;
         ST_RAD_W:   state_in = ST_INF;
         ST_INF:     state_in = ST_OX;
         ST_OX:      state_in = ST_ROT_O;
         ST_ROT_O:   state_in = ST_ROT_O_W;
         ST_ROT_O_W: state_in = cordic_stat.done ? ST_PX : ST_ROT_O_W;
         ST_PX:      state_in = ST_PY;
         ST_PY:      state_in = ST_ROT_P;
         ST_ROT_P:   state_in = ST_ROT_P_W;
         ST_ROT_P_W: state_in = cordic_stat.done ? ST_SUM : ST_ROT_P_W;
         ST_SUM:     state_in = ST_CAM_OUT;
         ST_CAM_OUT: state_in = out_free ? ST_IDLE : ST_CAM_OUT;
         ST_FL_RD:   state_in = ST_FL_LD;
         ST_FL_LD:   state_in = (cam_count_ff == '0) ? ST_FUSE_OUT : ST_FC_RD;
         ST_FC_RD:   state_in = ST_FC_A;
         ST_FC_A:    state_in = ST_FC_B;
         ST_FC_B:    state_in = ST_FC_C;
         ST_FC_C:    state_in = (hit || cam_last) ? ST_FUSE_OUT : ST_FC_RD;
         ST_FUSE_OUT: begin
            if (out_free) begin
               state_in = fuse_last ? ST_IDLE : ST_FL_RD;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_chan.ready       = 1'b0;
      mul_en               = 1'b0;
      mul_a                = '0;
      mul_b                = '0;
      cordic_cmd.start     = 1'b0;
      cordic_cmd.vectoring = 1'b0;
      cx_in                = '0;
      cy_in                = '0;
      cz_in                = '0;
      cam_we               = 1'b0;
      lidar_we             = 1'b0;
      out_load             = 1'b0;
      fuse_done            = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            lidar_we = req_fire && (req_chan.action == ACT_LIDAR)
                       && (int'(lidar_count_ff) < MAX_LIDAR);
         end
         ST_NUM_U: begin
            mul_en = 1'b1;
            mul_a  = MW'($signed({1'b0, tanh_ff}));
            mul_b  = MW'(diff);
         end
         ST_NUM_T: begin
            mul_en = 1'b1;
            mul_a  = MW'($signed({1'b0, tanh_ff}));
            mul_b  = MW'(diff2w);
         end
         ST_VEC: begin
            cordic_cmd.start     = 1'b1;
            cordic_cmd.vectoring = 1'b1;
            cx_in                = CW'(ONE_Q16);
            cy_in                = CW'(u_ff);
         end
         ST_KD: begin
            mul_en = 1'b1;
            mul_a  = MW'($signed({1'b0, d_ff}));
            mul_b  = KGAIN;
         end
         ST_ROT_D: begin
            cordic_cmd.start = 1'b1;
            cx_in            = CW'(prod_ff >>> 16);
            cz_in            = theta_ff;
         end
         ST_RAD: begin
            mul_en = 1'b1;
            mul_a  = MW'(dx_ff);
            mul_b  = MW'(t2_ff);
         end
         ST_INF: begin
            mul_en = 1'b1;
            mul_a  = MW'(rad_ff);
            mul_b  = MW'($signed({1'b0, gain_ff}));
         end
         ST_OX: begin
            mul_en = 1'b1;
            mul_a  = MW'($signed({1'b0, offset_ff}));
            mul_b  = KGAIN;
         end
         ST_ROT_O: begin
            cordic_cmd.start = 1'b1;
            cx_in            = CW'(prod_ff >>> 16);
            cz_in            = yaw;
         end
         ST_PX: begin
            mul_en = 1'b1;
            mul_a  = MW'(dx_ff);
            mul_b  = KGAIN;
         end
         ST_PY: begin
            mul_en = 1'b1;
            mul_a  = MW'(dy_ff);
            mul_b  = KGAIN;
         end
         ST_ROT_P: begin
            cordic_cmd.start = 1'b1;
            cx_in            = pxk_ff;
            cy_in            = CW'(prod_ff >>> 16);
            cz_in            = yaw;
         end
         ST_CAM_OUT: begin
            out_load = out_free;
            cam_we   = out_free && (int'(cam_count_ff) < MAX_CAMERA);
         end
         ST_FUSE_OUT: begin
            out_load  = out_free;
            fuse_done = out_free && fuse_last;
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cam_count_ff   <= '0;
         lidar_count_ff <= '0;
         j_ff           <= '0;
         c_ff           <= '0;
         nres_ff        <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (lidar_we) begin
            lidar_count_ff <= lidar_count_ff + 1'b1;
         end
         if (cam_we) begin
            cam_count_ff <= cam_count_ff + 1'b1;
         end
         if (state_ff == ST_IDLE && req_fire && req_chan.action == ACT_FUSE) begin
            j_ff    <= '0;
            nres_ff <= (int'(lidar_count_ff) > MAX_RESULTS) ? IDXW'(MAX_RESULTS)
                                                             : IDXW'(lidar_count_ff);
            if (lidar_count_ff == '0) begin
               cam_count_ff <= '0;
            end
         end
         if (fuse_done) begin
            cam_count_ff   <= '0;
            lidar_count_ff <= '0;
         end else if (out_load && state_ff == ST_FUSE_OUT) begin
            j_ff <= j_ff + 6'd1;
         end
         if (state_ff == ST_FL_LD) begin
            c_ff <= '0;
         end else if (state_ff == ST_FC_C && !hit) begin
            c_ff <= CCW'(c_ff + 1'b1);
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= PW'(mul_a * mul_b);
      end
      case (state_ff)
         ST_IDLE: begin
            cls_ff  <= req_chan.class_id;
            w_ff    <= req_chan.box_width;
            cx_ff   <= req_chan.center_col;
            d_ff    <= req_chan.depth;
            half_ff <= (half_reg_ff == '0) ? 12'd1 : half_reg_ff;
         end
         ST_NUM_T: begin
            div_num_ff <= prod_abs[DNW-1:0];
            div_neg_ff <= prod_ff[PW-1];
            div_den_ff <= {1'b0, half_ff};
            div_rem_ff <= '0;
            div_cnt_ff <= 6'(DNW);
         end
         ST_LD_T: begin
            u_ff       <= $signed(quot[31:0]);
            div_num_ff <= prod_abs[DNW-1:0];
            div_neg_ff <= prod_ff[PW-1];
            div_den_ff <= {half_ff, 1'b0};
            div_rem_ff <= '0;
            div_cnt_ff <= 6'(DNW);
         end
         ST_DIV_U, ST_DIV_T: begin
            div_rem_ff <= div_ge ? 13'(rem_sh - {1'b0, div_den_ff}) : rem_sh[12:0];
            div_num_ff <= {div_num_ff[DNW-2:0], div_ge};
            div_cnt_ff <= div_cnt_ff - 6'd1;
         end
         ST_VEC: t2_ff <= $signed(quot[31:0]);
         ST_VEC_W: theta_ff <= cz_out;
         ST_ROT_D_W: begin
            dx_ff <= cx_out;
            dy_ff <= cy_out;
         end
         ST_RAD_W: rad_ff <= sat32(SATW'(prod_ff >>> 16) - SATW'(dy_ff));
         ST_OX: infl_ff <= sat32(SATW'(prod_ff >>> 16));
         ST_ROT_O_W: begin
            ox_ff <= cx_out;
            oy_ff <= cy_out;
         end
         ST_PY: pxk_ff <= CW'(prod_ff >>> 16);
         ST_SUM: begin
            posx_ff <= sat32(SATW'(car_x_ff) + SATW'(ox_ff) + SATW'(cx_out));
            posy_ff <= sat32(SATW'(car_y_ff) + SATW'(oy_ff) + SATW'(cy_out));
         end
         ST_FL_LD: begin
            lx_ff    <= $signed(lidar_rdata[63:32]);
            ly_ff    <= $signed(lidar_rdata[31:0]);
            match_ff <= '0;
         end
         ST_FC_A: begin
            cls_c_ff <= cam_rdata[103:96];
            ok_ff    <= !cam_rdata[31] && (cam_rdata[31:0] != '0)
                        && (exa < {1'b0, cam_rdata[31:0]})
                        && (eya < {1'b0, cam_rdata[31:0]});
            ex_ff    <= exa[30:0];
            ey_ff    <= eya[30:0];
            r_ff     <= cam_rdata[30:0];
         end
         ST_FC_B: begin
            hit_ok_ff <= ok_ff;
            sq_ff     <= 63'(ex_ff * ex_ff) + 63'(ey_ff * ey_ff);
            rr_ff     <= 62'(r_ff * r_ff);
         end
         ST_FC_C: begin
            if (hit) begin
               match_ff <= cls_c_ff;
            end
         end
         default: ;
      endcase
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         if (state_ff == ST_CAM_OUT) begin
            out_kind_ff <= KIND_CAMERA;
            out_idx_ff  <= IDXW'(cam_count_ff);
            out_px_ff   <= posx_ff;
            out_py_ff   <= posy_ff;
            out_rad_ff  <= rad_ff;
            out_infl_ff <= infl_ff;
            out_cls_ff  <= cls_ff;
            out_last_ff <= 1'b1;
         end else begin
            out_kind_ff <= KIND_LIDAR;
            out_idx_ff  <= j_ff;
            out_px_ff   <= lx_ff;
            out_py_ff   <= ly_ff;
            out_rad_ff  <= '0;
            out_infl_ff <= '0;
            out_cls_ff  <= match_ff;
            out_last_ff <= fuse_last;
         end
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.kind            = out_kind_ff;
   assign rsp_chan.entry_index     = out_idx_ff;
   assign rsp_chan.pos_x           = out_px_ff;
   assign rsp_chan.pos_y           = out_py_ff;
   assign rsp_chan.obstacle_radius = out_rad_ff;
   assign rsp_chan.inflated_radius = out_infl_ff;
   assign rsp_chan.fused_class     = out_cls_ff;
   assign rsp_chan.last            = out_last_ff;

   assign cam_wdata = {cls_ff, posx_ff, posy_ff, rad_ff};

   clof_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cordic_cmd),
      .x_in  (cx_in),
      .y_in  (cy_in),
      .z_in  (cz_in),
      .stat  (cordic_stat),
      .x_out (cx_out),
      .y_out (cy_out),
      .z_out (cz_out)
   );

   clof_ram #(
      .WIDTH (CMW),
      .DEPTH (MAX_CAMERA)
   ) u_cam_ram (
      .clock (clock),
      .we    (cam_we),
      .waddr (CAW'(cam_count_ff)),
      .wdata (cam_wdata),
      .raddr (CAW'(c_ff)),
      .rdata (cam_rdata)
   );

   clof_ram #(
      .WIDTH (LMW),
      .DEPTH (MAX_LIDAR)
   ) u_lidar_ram (
      .clock (clock),
      .we    (lidar_we),
      .waddr (LAW'(lidar_count_ff)),
      .wdata ({req_chan.lidar_x, req_chan.lidar_y}),
      .raddr (LAW'(j_ff)),
      .rdata (lidar_rdata)
   );

   `CLOF_ASSERT_IMP(a_cam_bound, clock, reset, 1'b1, int'(cam_count_ff) <= MAX_CAMERA)
   `CLOF_ASSERT_IMP(a_out_no_overwrite, clock, reset, out_load, !out_valid_ff || rsp_chan.ready)
   `CLOF_ASSERT_NEXT(a_fuse_clears, clock, reset, fuse_done, (cam_count_ff == '0) && (lidar_count_ff == '0))
   `CLOF_ASSERT_IMP(a_cordic_free, clock, reset, cordic_cmd.start, !cordic_stat.busy)

endmodule

>>> verif/camera_lidar_obstacle_fusion_checker.sv
// ----------------------------------------------------------------------------
// camera_lidar_obstacle_fusion_checker
// watches the request, response and register channels of the fusion block,
// predicts every response from its own copy of the tables and registers and
// compares each response field by field with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camera_lidar_obstacle_fusion_checker
   import clof_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   clof_req_if                req,
   clof_rsp_if                rsp,
   clof_csr_if                csr,
   output int                 fail_count,
   output int                 pending,
   output logic signed [31:0] last_obs_x,
   output logic signed [31:0] last_obs_y,
   output logic signed [31:0] last_obs_r,
   output int                 cam_seen,
   output int                 fused_seen,
   output int                 matched_seen
);

   typedef struct {
      logic               kind;
      logic        [5:0]  entry_index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] obstacle_radius;
      logic signed [31:0] inflated_radius;
      logic        [7:0]  fused_class;
      logic               last;
   } obstacle_rsp_t;

   obstacle_rsp_t expected_rsps[$];

   logic signed [31:0] car_x, car_y;
   logic signed [18:0] heading;
   logic        [17:0] tan_half, gain;
   logic        [19:0] cam_offset;
   logic        [11:0] half_width;

   logic        [7:0]  obs_class[16];
   longint             obs_x[16], obs_y[16], obs_r[16];
   int                 obs_count;
   longint             pt_x[32], pt_y[32];
   int                 pt_count;

   function automatic longint arc_step(int i);
      longint steps[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2, 1};
      return (i < 17) ? steps[i] : 0;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint gain_comp(longint v);
      return (v * 39797) >>> 16;
   endfunction

   function automatic longint bearing(longint u);
      longint x, y, z, xs, ys;
      x = 65536;
      y = u;
      z = 0;
      for (int i = 0; i < 18; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += arc_step(i);
         end else begin
            x -= ys; y += xs; z -= arc_step(i);
         end
      end
      return z;
   endfunction

   task automatic turn(inout longint x, inout longint y, input longint z);
      longint xs, ys;
      if (z > 102944) begin
         z -= 205887; x = -x; y = -y;
      end else if (z < -102944) begin
         z += 205887; x = -x; y = -y;
      end
      for (int i = 0; i < 18; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= arc_step(i);
         end else begin
            x += ys; y -= xs; z += arc_step(i);
         end
      end
   endtask

   function automatic bit inside_circle(int c, longint lx, longint ly);
      longint r, ex, ey;
      r = obs_r[c];
      ex = obs_x[c] - lx;
      ey = obs_y[c] - ly;
      if (r <= 0) return 0;
      if (ex < 0) ex = -ex;
      if (ey < 0) ey = -ey;
      if (ex >= r || ey >= r) return 0;
      return (ex * ex + ey * ey) < (r * r);
   endfunction

   task automatic deproject(input logic [7:0] cls, input longint w, input longint cx,
                            input longint d);
      obstacle_rsp_t e;
      longint half, diff, u, t2, theta, dx, dy, rad, infl, ox, oy, px, py, yaw;
      half = (half_width == 0) ? 1 : half_width;
      yaw = heading;
      diff = half - cx;
      u = (longint'(tan_half) * diff) / half;
      t2 = (longint'(tan_half) * (2 * diff + w)) / (2 * half);
      theta = bearing(u);
      dx = gain_comp(d);
      dy = 0;
      turn(dx, dy, theta);
      rad = clip32(((dx * t2) >>> 16) - dy);
      infl = clip32((rad * longint'(gain)) >>> 16);
      ox = gain_comp(cam_offset);
      oy = 0;
      turn(ox, oy, yaw);
      px = gain_comp(dx);
      py = gain_comp(dy);
      turn(px, py, yaw);
      px = clip32(longint'(car_x) + ox + px);
      py = clip32(longint'(car_y) + oy + py);
      e.kind = KIND_CAMERA;
      e.entry_index = obs_count[5:0];
      e.pos_x = px[31:0];
      e.pos_y = py[31:0];
      e.obstacle_radius = rad[31:0];
      e.inflated_radius = infl[31:0];
      e.fused_class = cls;
      e.last = 1'b1;
      expected_rsps.push_back(e);
      if (obs_count < 16) begin
         obs_class[obs_count] = cls;
         obs_x[obs_count] = px;
         obs_y[obs_count] = py;
         obs_r[obs_count] = rad;
         obs_count++;
      end
      last_obs_x <= px[31:0];
      last_obs_y <= py[31:0];
      last_obs_r <= rad[31:0];
   endtask

   task automatic fuse_tables();
      obstacle_rsp_t e;
      int n;
      n = (pt_count > 32) ? 32 : pt_count;
      for (int j = 0; j < n; j++) begin
         e.fused_class = 8'd0;
         for (int c = 0; c < obs_count; c++) begin
            if (inside_circle(c, pt_x[j], pt_y[j])) begin
               e.fused_class = obs_class[c];
               break;
            end
         end
         e.kind = KIND_LIDAR;
         e.entry_index = j[5:0];
         e.pos_x = pt_x[j][31:0];
         e.pos_y = pt_y[j][31:0];
         e.obstacle_radius = '0;
         e.inflated_radius = '0;
         e.last = (j + 1 == n);
         expected_rsps.push_back(e);
      end
      obs_count = 0;
      pt_count = 0;
   endtask

   function automatic void report(string field, longint exp_v, longint act_v);
      fail_count++;
      if (fail_count <= 10) begin
         $display("mismatch %s: expected %0d actual %0d", field, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      obstacle_rsp_t e;
      if (reset) begin
         car_x = 0; car_y = 0; heading = 0;
         tan_half = TAN_HALF_VIEW_RST; cam_offset = CAMERA_OFFSET_RST;
         half_width = HALF_IMG_WIDTH_RST; gain = RADIUS_GAIN_RST;
         obs_count = 0; pt_count = 0;
         expected_rsps.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_CAR_POS_X:      car_x = csr.data;
               REG_CAR_POS_Y:      car_y = csr.data;
               REG_CAR_HEADING:    heading = csr.data[18:0];
               REG_TAN_HALF_VIEW:  tan_half = csr.data[17:0];
               REG_CAMERA_OFFSET:  cam_offset = csr.data[19:0];
               REG_HALF_IMG_WIDTH: half_width = csr.data[11:0];
               REG_RADIUS_GAIN:    gain = csr.data[17:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response, index %0d", rsp.entry_index);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp.kind !== e.kind) report("kind", e.kind, rsp.kind);
               else if (rsp.entry_index !== e.entry_index)
                  report("entry_index", e.entry_index, rsp.entry_index);
               else if (rsp.pos_x !== e.pos_x) report("pos_x", e.pos_x, rsp.pos_x);
               else if (rsp.pos_y !== e.pos_y) report("pos_y", e.pos_y, rsp.pos_y);
               else if (rsp.obstacle_radius !== e.obstacle_radius)
                  report("obstacle_radius", e.obstacle_radius, rsp.obstacle_radius);
               else if (rsp.inflated_radius !== e.inflated_radius)
                  report("inflated_radius", e.inflated_radius, rsp.inflated_radius);
               else if (rsp.fused_class !== e.fused_class)
                  report("fused_class", e.fused_class, rsp.fused_class);
               else if (rsp.last !== e.last) report("last", e.last, rsp.last);
               if (e.kind == KIND_CAMERA) cam_seen++;
               else begin
                  fused_seen++;
                  if (e.fused_class != 0) matched_seen++;
               end
            end
         end
         if (req.valid && req.ready) begin
            case (req.action)
               ACT_CAMERA: deproject(req.class_id, req.box_width, req.center_col, req.depth);
               ACT_LIDAR: begin
                  if (pt_count < 32) begin
                     pt_x[pt_count] = req.lidar_x;
                     pt_y[pt_count] = req.lidar_y;
                     pt_count++;
                  end
               end
               ACT_FUSE: fuse_tables();
               default: ;
            endcase
         end
      end
      pending <= expected_rsps.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      cam_seen = 0;
      fused_seen = 0;
      matched_seen = 0;
      last_obs_x = 0;
      last_obs_y = 0;
      last_obs_r = 0;
   end

endmodule

>>> verif/camera_lidar_obstacle_fusion_tb.sv
// ----------------------------------------------------------------------------
// camera_lidar_obstacle_fusion_tb
// drives camera, lidar and fuse requests in bursts through several register
// settings while the response side stalls, and reports the checker verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camera_lidar_obstacle_fusion_tb;
   import clof_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;

   logic clock;
   logic reset;
   int   cycles;
   int   burst_left;
   int   requests_sent;
   int   fail_count, pending, cam_seen, fused_seen, matched_seen;
   logic signed [31:0] last_obs_x, last_obs_y, last_obs_r;

   clof_req_if req_chan();
   clof_rsp_if rsp_chan();
   clof_csr_if csr_chan();

   camera_lidar_obstacle_fusion i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   camera_lidar_obstacle_fusion_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .csr          (csr_chan),
      .fail_count   (fail_count),
      .pending      (pending),
      .last_obs_x   (last_obs_x),
      .last_obs_y   (last_obs_y),
      .last_obs_r   (last_obs_r),
      .cam_seen     (cam_seen),
      .fused_seen   (fused_seen),
      .matched_seen (matched_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("camera_lidar_obstacle_fusion regression: fail");
         $finish;
      end
   end

   // response stall pattern is chosen by bits 10:9 of the cycle counter
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         case (cycles[10:9])
            2'd0: rsp_chan.ready <= 1'b1;
            2'd1: rsp_chan.ready <= $urandom_range(0, 1);
            2'd2: rsp_chan.ready <= (cycles % 7) != 0;
            default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_request(logic [1:0] act, logic [7:0] cls, logic [12:0] w,
                               logic [12:0] cx, logic [23:0] d,
                               logic signed [31:0] lx, logic signed [31:0] ly);
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_chan.action <= act;
      req_chan.class_id <= cls;
      req_chan.box_width <= w;
      req_chan.center_col <= cx;
      req_chan.depth <= d;
      req_chan.lidar_x <= lx;
      req_chan.lidar_y <= ly;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      burst_left--;
      if (act != 2'd3) requests_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
      repeat (3000) @(posedge clock);
   endtask

   task automatic write_regs(logic [31:0] vals[7]);
      for (int i = 0; i < 7; i++) begin
         csr_chan.index <= i[2:0];
         csr_chan.data <= vals[i];
         csr_chan.valid <= 1'b1;
         do @(posedge clock); while (!csr_chan.ready);
      end
      csr_chan.valid <= 1'b0;
   endtask

   task automatic random_camera();
      logic [12:0] cx;
      logic [23:0] d;
      cx = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 1280));
      d = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4194304));
      send_request(ACT_CAMERA, 8'($urandom), 13'($urandom_range(0, 600)) |
                   (($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'd0), cx, d, 0, 0);
   endtask

   task automatic random_lidar();
      longint r, lx, ly;
      if ($urandom_range(0, 9) < 6) begin
         r = last_obs_r;
         if (r < 1) r = 65536;
         if (r > 64'sd33554432) r = 64'sd33554432;
         lx = longint'(last_obs_x) + longint'($urandom_range(0, 2 * r)) - r;
         ly = longint'(last_obs_y) + longint'($urandom_range(0, 2 * r)) - r;
         if (lx > 64'sd2147483647) lx = 64'sd2147483647;
         if (lx < -64'sd2147483648) lx = -64'sd2147483648;
         if (ly > 64'sd2147483647) ly = 64'sd2147483647;
         if (ly < -64'sd2147483648) ly = -64'sd2147483648;
      end else begin
         lx = $signed($urandom);
         ly = $signed($urandom);
      end
      send_request(ACT_LIDAR, 0, 0, 0, 0, lx[31:0], ly[31:0]);
   endtask

   task automatic random_phase(int target);
      int ncam, npt;
      while (requests_sent < target) begin
         ncam = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 4);
         npt = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 6);
         for (int i = 0; i < ncam; i++) begin
            random_camera();
            if ($urandom_range(0, 2) == 0) random_lidar();
         end
         for (int i = 0; i < npt; i++) random_lidar();
         if ($urandom_range(0, 9) == 0) begin
            send_request(2'($urandom), 8'($urandom), 13'($urandom), 13'($urandom),
                         24'($urandom), $urandom, $urandom);
         end
         if ($urandom_range(0, 11) != 0) send_request(ACT_FUSE, 0, 0, 0, 0, 0, 0);
      end
   endtask

   initial begin
      logic [31:0] setting[7];
      cycles = 0;
      burst_left = 0;
      requests_sent = 0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.action <= '0;
      req_chan.class_id <= '0;
      req_chan.box_width <= '0;
      req_chan.center_col <= '0;
      req_chan.depth <= '0;
      req_chan.lidar_x <= '0;
      req_chan.lidar_y <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= '0;
      csr_chan.data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests at reset settings
      send_request(ACT_FUSE, 0, 0, 0, 0, 0, 0);
      send_request(ACT_CAMERA, 8'd0, 13'd0, 13'd0, 24'd0, 0, 0);
      send_request(ACT_CAMERA, 8'd255, 13'd8191, 13'd8191, 24'hFFFFFF, 0, 0);
      send_request(ACT_CAMERA, 8'd7, 13'd100, 13'd640, 24'd655360, 0, 0);
      send_request(ACT_FUSE, 0, 0, 0, 0, 0, 0);
      send_request(ACT_LIDAR, 0, 0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000);
      send_request(ACT_LIDAR, 0, 0, 0, 0, 32'sh80000000, 32'sh7FFFFFFF);
      send_request(ACT_FUSE, 0, 0, 0, 0, 0, 0);
      send_request(ACT_CAMERA, 8'd42, 13'd200, 13'd640, 24'd655360, 0, 0);
      send_request(ACT_LIDAR, 0, 0, 0, 0, last_obs_x, last_obs_y);
      send_request(ACT_LIDAR, 0, 0, 0, 0, 32'sd144179 + 32'sd655360, 0);
      send_request(ACT_LIDAR, 0, 0, 0, 0, 0, 0);
      send_request(2'd3, 8'hFF, 13'h1FFF, 13'h1FFF, 24'hFFFFFF, -1, -1);
      send_request(ACT_FUSE, 0, 0, 0, 0, 0, 0);
      send_request(ACT_CAMERA, 8'd1, 13'd4096, 13'd4096, 24'h800000, 0, 0);
      send_request(ACT_CAMERA, 8'd2, 13'd50, 13'd1280, 24'd65536, 0, 0);
      send_request(ACT_FUSE, 0, 0, 0, 0, 0, 0);
      drain();

      setting = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'd205887, 32'd262143, 32'd1048575,
                  32'd4095, 32'd262143};
      write_regs(setting);
      random_phase(130);
      drain();

      setting = '{32'h80000000, 32'h80000000, 32'h7CDC1, 32'd0, 32'd0, 32'd0, 32'd0};
      write_regs(setting);
      send_request(ACT_CAMERA, 8'd9, 13'd10, 13'd0, 24'd655360, 0, 0);
      random_phase(220);
      drain();

      setting = '{32'd0, 32'd0, 32'd0, 32'd60052, 32'd144179, 32'd1, 32'd72090};
      write_regs(setting);
      random_phase(300);
      drain();

      setting = '{$urandom, $urandom, 32'($urandom_range(0, 411774)) - 32'd205887,
                  32'($urandom_range(0, 262143)), 32'($urandom_range(0, 1048575)),
                  32'($urandom_range(1, 4095)), 32'($urandom_range(0, 262143))};
      write_regs(setting);
      random_phase(380);
      drain();

      setting = '{32'd3276800, 32'hFFCE0000, 32'd51472, 32'd60052, 32'd144179,
                  32'd640, 32'd72090};
      write_regs(setting);
      random_phase(470);
      drain();

      $display("covered %0d requests: %0d camera obstacles, %0d fused lidar centers",
               requests_sent, cam_seen, fused_seen);
      $display("%0d lidar centers matched a camera class, over six register settings",
               matched_seen);
      if (fail_count == 0) begin
         $display("camera_lidar_obstacle_fusion regression: pass");
      end else begin
         $display("camera_lidar_obstacle_fusion regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/clof_pkg.sv
rtl/clof_if.sv
rtl/clof_ram.sv
rtl/clof_cordic.sv
rtl/camera_lidar_obstacle_fusion.sv
verif/camera_lidar_obstacle_fusion_checker.sv
verif/camera_lidar_obstacle_fusion_tb.sv
